[hw/rtl/tqe_pkg.sv]
// ----------------------------------------------------------------------------
// tqe_pkg
// Shared constants, codes and types of the timer queue engine.
// ----------------------------------------------------------------------------
package tqe_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntBits    = (MaxResults > 1) ? $clog2(MaxResults) : 1;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpCancel = 2'd1,
    OpQuery  = 2'd2,
    OpTick   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    OcStarted   = 3'd0,
    OcFull      = 3'd1,
    OcCancelled = 3'd2,
    OcNotFound  = 3'd3,
    OcRunning   = 3'd4,
    OcIdle      = 3'd5,
    OcExpired   = 3'd6
  } outcome_e;

  typedef enum logic [1:0] {
    CellHold   = 2'd0,
    CellInsert = 2'd1,
    CellRemove = 2'd2,
    CellPop    = 2'd3
  } cell_mode_e;

  typedef struct packed {
    logic                valid;
    logic [IdBits-1:0]   id;
    logic [TimeBits-1:0] deadline;
  } entry_t;

  typedef struct packed {
    cell_mode_e          mode;
    logic [IdBits-1:0]   key_id;
    logic [TimeBits-1:0] key_time;
  } cell_ctrl_t;

endpackage

[hw/rtl/timer_queue_engine_unit.sv]
// ----------------------------------------------------------------------------
// timer_queue_engine_unit
// Sorted queue of pending timers built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each transaction is registered when taken in the idle state and executed in
// the execute state, which waits while a stalled result holds the output
// register. Start, cancel and query use the single execute step of the cell
// chain. A tick with nothing due returns to idle without a result; otherwise
// expirations leave the head of the chain one per cycle while the output is not
// stalled, up to MaxResults per tick. Results go to an output register, so a new
// transaction is taken while a result still waits.
module timer_queue_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [tqe_pkg::IdBits-1:0]   timer_id_i,
  input  logic [tqe_pkg::TimeBits-1:0] time_value_i,
  input  logic                         relative_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   outcome_o,
  output logic [tqe_pkg::IdBits-1:0]   result_id_o,
  output logic                         last_o
);

  localparam int unsigned D = tqe_pkg::Depth;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e                        state_q, state_d;
  tqe_pkg::op_e                  op_q;
  logic [tqe_pkg::IdBits-1:0]    id_q;
  logic [tqe_pkg::TimeBits-1:0]  key_q, key_d;
  logic [tqe_pkg::TimeBits-1:0]  cur_q;
  logic [tqe_pkg::TimeBits:0]    rel_sum;
  logic [tqe_pkg::CntBits-1:0]   cnt_q;
  logic                          accept;
  logic                          out_free;
  logic                          out_valid_q;
  tqe_pkg::outcome_e             outcome_q;
  logic [tqe_pkg::IdBits-1:0]    result_id_q;
  logic                          last_q;
  logic                          emit;
  tqe_pkg::outcome_e             emit_outcome;
  logic [tqe_pkg::IdBits-1:0]    emit_id;
  logic                          emit_last;
  logic                          drain_next;
  tqe_pkg::cell_ctrl_t           ctrl;

  tqe_pkg::entry_t entries [D];
  tqe_pkg::entry_t left_e  [D];
  tqe_pkg::entry_t right_e [D];
  logic            le      [D];
  logic            left_le [D];
  logic            m_in    [D];
  logic            m_out   [D];

  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign rel_sum  = {1'b0, cur_q} + {1'b0, time_value_i};

  always_comb begin
    key_d = time_value_i;
    if ((tqe_pkg::op_e'(op_i) == tqe_pkg::OpStart) && relative_i) begin
      key_d = rel_sum[tqe_pkg::TimeBits] ? {tqe_pkg::TimeBits{1'b1}}
                                         : rel_sum[tqe_pkg::TimeBits-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    emit         = 1'b0;
    emit_outcome = tqe_pkg::OcStarted;
    emit_id      = id_q;
    emit_last    = 1'b1;
    drain_next   = 1'b0;
    ctrl.mode    = tqe_pkg::CellHold;
    ctrl.key_id  = id_q;
    ctrl.key_time = key_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        case (op_q)
          tqe_pkg::OpStart: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
              if (entries[D-1].valid) begin
                emit_outcome = tqe_pkg::OcFull;
              end else begin
                emit_outcome = tqe_pkg::OcStarted;
                ctrl.mode    = tqe_pkg::CellInsert;
              end
            end
          end
          tqe_pkg::OpCancel: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = StIdle;
              if (m_out[D-1] && (id_q != '0)) begin
                emit_outcome = tqe_pkg::OcCancelled;
                ctrl.mode    = tqe_pkg::CellRemove;
              end else begin
                emit_outcome = tqe_pkg::OcNotFound;
              end
            end
          end
          tqe_pkg::OpQuery: begin
            if (out_free) begin
              emit         = 1'b1;
              state_d      = StIdle;
              emit_outcome = m_out[D-1] ? tqe_pkg::OcRunning : tqe_pkg::OcIdle;
            end
          end
          tqe_pkg::OpTick: begin
            if (!le[0]) begin
              state_d = StIdle;
            end else if (out_free) begin
              emit         = 1'b1;
              drain_next   = 1'b1;
              emit_outcome = tqe_pkg::OcExpired;
              emit_id      = entries[0].id;
              emit_last    = !le[1] ||
                             (cnt_q == tqe_pkg::CntBits'(tqe_pkg::MaxResults - 1));
              ctrl.mode    = tqe_pkg::CellPop;
              if (emit_last) begin
                state_d = StIdle;
              end
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  for (genvar g = 0; g < D; g++) begin : gen_cell
    if (g == 0) begin : gen_head
      assign left_e[g]  = '0;
      assign left_le[g] = 1'b1;
      assign m_in[g]    = 1'b0;
    end else begin : gen_mid
      assign left_e[g]  = entries[g-1];
      assign left_le[g] = le[g-1];
      assign m_in[g]    = m_out[g-1];
    end
    if (g == D - 1) begin : gen_tail
      assign right_e[g] = '0;
    end else begin : gen_inner
      assign right_e[g] = entries[g+1];
    end

    tqe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left_e[g]),
      .left_le_i   (left_le[g]),
      .right_i     (right_e[g]),
      .match_in_i  (m_in[g]),
      .entry_o     (entries[g]),
      .le_o        (le[g]),
      .match_out_o (m_out[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
        if (tqe_pkg::op_e'(op_i) == tqe_pkg::OpTick) begin
          cur_q <= time_value_i;
        end
      end else if (drain_next) begin
        cnt_q <= cnt_q + tqe_pkg::CntBits'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= tqe_pkg::op_e'(op_i);
      id_q  <= timer_id_i;
      key_q <= key_d;
    end
    if (emit) begin
      outcome_q   <= emit_outcome;
      result_id_q <= emit_id;
      last_q      <= emit_last;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign result_id_o = result_id_q;
  assign last_o      = last_q;

endmodule

[hw/rtl/tqe_cell.sv]
// ----------------------------------------------------------------------------
// tqe_cell
// One slot of the sorted timer chain. It compares its entry against the
// broadcast key and takes its next entry from itself, its neighbors or the key.
// ----------------------------------------------------------------------------
module tqe_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tqe_pkg::cell_ctrl_t ctrl_i,
  input  tqe_pkg::entry_t     left_i,
  input  logic                left_le_i,
  input  tqe_pkg::entry_t     right_i,
  input  logic                match_in_i,
  output tqe_pkg::entry_t     entry_o,
  output logic                le_o,
  output logic                match_out_o
);

  logic                         valid_q;
  logic [tqe_pkg::IdBits-1:0]   id_q;
  logic [tqe_pkg::TimeBits-1:0] deadline_q;
  tqe_pkg::entry_t              entry_q;
  tqe_pkg::entry_t              entry_d;
  logic                         match;

  assign entry_q.valid    = valid_q;
  assign entry_q.id       = id_q;
  assign entry_q.deadline = deadline_q;

  assign le_o        = entry_q.valid && (entry_q.deadline <= ctrl_i.key_time);
  assign match       = entry_q.valid && (entry_q.id == ctrl_i.key_id);
  assign match_out_o = match_in_i || match;
  assign entry_o     = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.mode)
      tqe_pkg::CellInsert: begin
        if (!le_o) begin
          if (left_le_i) begin
            entry_d.valid    = 1'b1;
            entry_d.id       = ctrl_i.key_id;
            entry_d.deadline = ctrl_i.key_time;
          end else begin
            entry_d = left_i;
          end
        end
      end
      tqe_pkg::CellRemove: begin
        if (match_out_o) begin
          entry_d = right_i;
        end
      end
      tqe_pkg::CellPop: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= entry_d.id;
    deadline_q <= entry_d.deadline;
  end

endmodule

[dv/timer_queue_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// timer_queue_engine_unit_tb
// Self-checking testbench of the sorted timer queue engine.
// ----------------------------------------------------------------------------
// Commands (start, cancel, query, tick) are queued up front: first a directed
// set that covers the field extremes, id zero, relative saturation, a full
// queue, time going backwards and a tick that drains the whole queue, then
// random traffic built around a small pool of ids. A clocked driver sends the
// commands with random idle bursts. At each accepted transaction a timer
// queue model predicts the outcomes. A clocked monitor applies random stall
// bursts and checks every accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module timer_queue_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 142;
  localparam int QuietItems  = 30;

  typedef struct {
    tqe_pkg::op_e                 op;
    logic [tqe_pkg::IdBits-1:0]   id;
    logic [tqe_pkg::TimeBits-1:0] tv;
    logic                         rel;
  } timer_cmd_t;

  typedef struct {
    tqe_pkg::outcome_e          outcome;
    logic [tqe_pkg::IdBits-1:0] id;
    logic                       last;
  } timer_result_t;

  logic                         clk_i;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   op_i         = '0;
  logic [tqe_pkg::IdBits-1:0]   timer_id_i   = '0;
  logic [tqe_pkg::TimeBits-1:0] time_value_i = '0;
  logic                         relative_i   = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i  = 1'b0;
  logic [2:0]                   outcome_o;
  logic [tqe_pkg::IdBits-1:0]   result_id_o;
  logic                         last_o;

  timer_cmd_t          command_q[$];
  timer_cmd_t          cur_cmd;
  timer_result_t       outcome_q[$];
  timer_result_t       want;

  logic [tqe_pkg::IdBits-1:0]   timer_id_mdl[tqe_pkg::Depth];
  logic [tqe_pkg::TimeBits-1:0] timer_deadline_mdl[tqe_pkg::Depth];
  int                           timer_count = 0;
  logic [tqe_pkg::TimeBits-1:0] now_time    = '0;
  logic [tqe_pkg::TimeBits-1:0] gen_time    = '0;

  int                  error_count = 0;
  int                  cycle_count = 0;
  int                  send_gap    = 0;
  int                  stall_left  = 0;

  timer_queue_engine_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .timer_id_i   (timer_id_i),
    .time_value_i (time_value_i),
    .relative_i   (relative_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .result_id_o  (result_id_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    $display("mismatch on %s: got %0h, expected %0h (cycle %0d)",
             what, got, exp_val, cycle_count);
    error_count++;
  endtask

  task automatic push_outcome(input tqe_pkg::outcome_e oc,
                              input logic [tqe_pkg::IdBits-1:0] id,
                              input logic last);
    timer_result_t r;
    r.outcome = oc;
    r.id      = id;
    r.last    = last;
    outcome_q = {outcome_q, r};
  endtask

  task automatic remove_timer(input int pos);
    for (int i = pos; i + 1 < timer_count; i++) begin
      timer_id_mdl[i]       = timer_id_mdl[i + 1];
      timer_deadline_mdl[i] = timer_deadline_mdl[i + 1];
    end
    timer_count--;
  endtask

  task automatic predict_outcomes(input timer_cmd_t c);
    logic [tqe_pkg::TimeBits:0]   sum;
    logic [tqe_pkg::TimeBits-1:0] deadline;
    int                           pos;
    int                           due;
    bit                           found;
    case (c.op)
      tqe_pkg::OpStart: begin
        sum      = {1'b0, now_time} + {1'b0, c.tv};
        deadline = !c.rel ? c.tv
                          : (sum[tqe_pkg::TimeBits] ? '1 : sum[tqe_pkg::TimeBits-1:0]);
        if (timer_count >= tqe_pkg::Depth) begin
          push_outcome(tqe_pkg::OcFull, c.id, 1'b1);
        end else begin
          pos = 0;
          while (pos < timer_count && timer_deadline_mdl[pos] <= deadline) pos++;
          for (int i = timer_count; i > pos; i--) begin
            timer_id_mdl[i]       = timer_id_mdl[i - 1];
            timer_deadline_mdl[i] = timer_deadline_mdl[i - 1];
          end
          timer_id_mdl[pos]       = c.id;
          timer_deadline_mdl[pos] = deadline;
          timer_count++;
          push_outcome(tqe_pkg::OcStarted, c.id, 1'b1);
        end
      end
      tqe_pkg::OpCancel: begin
        found = 1'b0;
        if (c.id != '0) begin
          for (int i = 0; i < timer_count && !found; i++) begin
            if (timer_id_mdl[i] == c.id) begin
              remove_timer(i);
              found = 1'b1;
            end
          end
        end
        push_outcome(found ? tqe_pkg::OcCancelled : tqe_pkg::OcNotFound, c.id, 1'b1);
      end
      tqe_pkg::OpQuery: begin
        found = 1'b0;
        for (int i = 0; i < timer_count; i++) begin
          if (timer_id_mdl[i] == c.id) found = 1'b1;
        end
        push_outcome(found ? tqe_pkg::OcRunning : tqe_pkg::OcIdle, c.id, 1'b1);
      end
      default: begin
        now_time = c.tv;
        due = 0;
        while (due < timer_count && due < tqe_pkg::MaxResults &&
               timer_deadline_mdl[due] <= c.tv) begin
          due++;
        end
        for (int i = 0; i < due; i++) begin
          push_outcome(tqe_pkg::OcExpired, timer_id_mdl[i], (i + 1 == due));
        end
        for (int i = 0; i < due; i++) begin
          remove_timer(0);
        end
      end
    endcase
  endtask

  task automatic push_cmd(input tqe_pkg::op_e op, input logic [tqe_pkg::IdBits-1:0] id,
                          input logic [tqe_pkg::TimeBits-1:0] tv, input logic rel);
    timer_cmd_t c;
    c.op  = op;
    c.id  = id;
    c.tv  = tv;
    c.rel = rel;
    if (op == tqe_pkg::OpTick) gen_time = tv;
    command_q = {command_q, c};
  endtask

  function automatic logic [tqe_pkg::TimeBits-1:0] rand_time();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[tqe_pkg::TimeBits-1:0];
  endfunction

  function automatic logic [tqe_pkg::IdBits-1:0] rand_id();
    if ($urandom_range(0, 99) < 15) return tqe_pkg::IdBits'($urandom);
    return tqe_pkg::IdBits'($urandom_range(0, 11));
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timer_queue_engine_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_outcomes(cur_cmd);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (command_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (command_q.size() > QuietItems && $urandom_range(0, 99) < 25) begin
          send_gap = $urandom_range(1, 14) - 1;
          in_valid_i <= 1'b0;
        end else begin
          cur_cmd = command_q[0];
          command_q.delete(0);
          in_valid_i   <= 1'b1;
          op_i         <= cur_cmd.op;
          timer_id_i   <= cur_cmd.id;
          time_value_i <= cur_cmd.tv;
          relative_i   <= cur_cmd.rel;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with no prediction", 64'(result_id_o), '0);
        end else begin
          want = outcome_q[0];
          outcome_q.delete(0);
          if (outcome_o !== want.outcome) begin
            report_mismatch("outcome", 64'(outcome_o), 64'(want.outcome));
          end
          if (result_id_o !== want.id) begin
            report_mismatch("result_id", 64'(result_id_o), 64'(want.id));
          end
          if (last_o !== want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (command_q.size() > QuietItems && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int                           r;
    logic                         rel;
    logic [tqe_pkg::TimeBits-1:0] tv;

    push_cmd(tqe_pkg::OpTick, 16'h0000, '0, 1'b0);
    push_cmd(tqe_pkg::OpQuery, 16'h0000, '0, 1'b0);
    push_cmd(tqe_pkg::OpCancel, 16'h0000, '0, 1'b1);
    push_cmd(tqe_pkg::OpStart, 16'h0000, 48'd100, 1'b0);
    push_cmd(tqe_pkg::OpQuery, 16'h0000, '1, 1'b1);
    push_cmd(tqe_pkg::OpCancel, 16'h0000, '0, 1'b0);
    push_cmd(tqe_pkg::OpStart, 16'hFFFF, '1, 1'b0);
    push_cmd(tqe_pkg::OpTick, 16'hFFFF, 48'hFFFF_FFFF_0000, 1'b1);
    push_cmd(tqe_pkg::OpStart, 16'h0005, '1, 1'b1);
    push_cmd(tqe_pkg::OpStart, 16'h0006, 48'h0000_0001_0000, 1'b1);
    push_cmd(tqe_pkg::OpTick, 16'h0000, 48'd50, 1'b0);
    push_cmd(tqe_pkg::OpStart, 16'h0007, 48'd10, 1'b1);
    push_cmd(tqe_pkg::OpCancel, 16'h0007, '0, 1'b0);
    for (int k = 0; k < tqe_pkg::Depth - 3; k++) begin
      push_cmd(tqe_pkg::OpStart, tqe_pkg::IdBits'(16'h0100 + k), 48'd1000, 1'b0);
    end
    push_cmd(tqe_pkg::OpStart, 16'h0200, 48'd10, 1'b0);
    push_cmd(tqe_pkg::OpTick, 16'h0000, '1, 1'b0);

    for (int k = 0; k < RandomItems; k++) begin
      r   = $urandom_range(0, 99);
      rel = 1'($urandom_range(0, 1));
      if (r < 40) begin
        if ($urandom_range(0, 99) < 10) tv = rand_time();
        else if (rel) tv = tqe_pkg::TimeBits'($urandom_range(0, 3000));
        else tv = gen_time + tqe_pkg::TimeBits'($urandom_range(0, 3000));
        push_cmd(tqe_pkg::OpStart, rand_id(), tv, rel);
      end else if (r < 58) begin
        push_cmd(tqe_pkg::OpCancel, rand_id(), rand_time(), rel);
      end else if (r < 72) begin
        push_cmd(tqe_pkg::OpQuery, rand_id(), rand_time(), rel);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) tv = gen_time + tqe_pkg::TimeBits'($urandom_range(0, 1500));
        else if (r < 92) tv = gen_time - tqe_pkg::TimeBits'($urandom_range(1, 500));
        else tv = rand_time();
        push_cmd(tqe_pkg::OpTick, rand_id(), tv, rel);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (command_q.size() != 0 || in_valid_i || outcome_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("timer_queue_engine_unit regression: pass");
    end else begin
      $display("timer_queue_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
